/* design/lat_pkg.sv */
// ----------------------------------------------------------------------------
// lat_pkg
// Shared types and constants of the toroidal life automaton: field widths,
// action codes, register indexes and the controller-to-datapath command word.
// ----------------------------------------------------------------------------
package lat_pkg;

	localparam int ACT_W      = 2;
	localparam int COL_W      = 9;
	localparam int ROW_W      = 8;
	localparam int S_DATA_W   = 24;
	localparam int M_DATA_W   = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;
	localparam int COLS_CFG_W = 10;
	localparam int ROWS_CFG_W = 9;

	localparam logic [COLS_CFG_W-1:0] COLS_RESET = 10'd480;
	localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 9'd250;
	localparam int                    MIN_SIZE   = 3;

	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] KEEP_COUNT  = 4'd2;

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE   = 2'd0,
		ACT_ADVANCE = 2'd1,
		ACT_READ    = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_COLUMNS = 1'b0,
		CFG_GRID_ROWS    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		WR_CLEAR,
		WR_CELL,
		WR_GEN
	} wr_kind_t;

	typedef struct packed {
		logic     item_load;
		logic     rd_en;
		logic     rd_item;
		logic     rd_plane;
		logic     wr_en;
		wr_kind_t wr_kind;
		logic     wr_plane;
		logic     win_shift;
		logic     cell_latch;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		action_t action;
	} status_t;

endpackage

/* design/lat_datapath.sv */
// ----------------------------------------------------------------------------
// lat_datapath
// Grid memory (two planes, one row per word), three-row window, next-row
// logic, item and result registers, and the size registers.
// ----------------------------------------------------------------------------
module lat_datapath #(
	parameter int MAX_COLUMNS = 512,
	parameter int MAX_ROWS    = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lat_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lat_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic [lat_pkg::S_DATA_W-1:0]        s_tdata,
	input  logic [lat_pkg::ACT_W-1:0]           s_tuser,
	input  lat_pkg::cmd_t                       cmd,
	input  logic [$clog2(MAX_ROWS)-1:0]         rd_row,
	input  logic [$clog2(MAX_ROWS)-1:0]         wr_row,
	output lat_pkg::status_t                    status,
	output logic [$clog2(MAX_ROWS+1)-1:0]       live_h,
	output logic [lat_pkg::M_DATA_W-1:0]        m_tdata,
	output logic [lat_pkg::ACT_W-1:0]           m_tuser
);
	import lat_pkg::*;

	localparam int CIW   = $clog2(MAX_COLUMNS);
	localparam int WW    = $clog2(MAX_COLUMNS + 1);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int AW    = RW + 1;
	localparam int DEPTH = 2 ** AW;

	function automatic logic [MAX_COLUMNS-1:0] wrap_left(
		input logic [MAX_COLUMNS-1:0] r,
		input logic [CIW-1:0]         last
	);
		return {r[MAX_COLUMNS-2:0], r[last]};
	endfunction

	function automatic logic [MAX_COLUMNS-1:0] wrap_right(
		input logic [MAX_COLUMNS-1:0] r,
		input logic [CIW-1:0]         last
	);
		logic [MAX_COLUMNS-1:0] v;
		v       = {1'b0, r[MAX_COLUMNS-1:1]};
		v[last] = r[0];
		return v;
	endfunction

	logic [COLS_CFG_W-1:0]  grid_columns_q;
	logic [ROWS_CFG_W-1:0]  grid_rows_q;
	logic [WW-1:0]          live_w;
	logic [CIW-1:0]         last_col;

	action_t                action_q;
	logic [COL_W-1:0]       col_q;
	logic [ROW_W-1:0]       row_q;
	logic                   cell_in_q;
	logic                   cell_q;
	logic                   in_area;
	logic [CIW-1:0]         col_idx;

	logic [MAX_COLUMNS-1:0] grid_mem [DEPTH];
	logic [MAX_COLUMNS-1:0] rd_data_q;
	logic [MAX_COLUMNS-1:0] up_q;
	logic [MAX_COLUMNS-1:0] mid_q;
	logic [MAX_COLUMNS-1:0] ul, ur, ml, mr, dl, dr;
	logic [MAX_COLUMNS-1:0] gen_row;
	logic [MAX_COLUMNS-1:0] gen_mask;
	logic [3:0]             nbr_cnt;

	logic [AW-1:0]          wr_addr;
	logic [AW-1:0]          rd_addr;
	logic [MAX_COLUMNS-1:0] wr_data;
	logic [MAX_COLUMNS-1:0] wr_mask;

	logic [ACT_W-1:0]       done_action_q;
	logic                   cell_out_q;

	// clamp the configured size into the supported range
	always_comb begin
		if (32'(grid_columns_q) < MIN_SIZE)
			live_w = WW'(MIN_SIZE);
		else if (32'(grid_columns_q) > MAX_COLUMNS)
			live_w = WW'(MAX_COLUMNS);
		else
			live_w = WW'(grid_columns_q);
		if (32'(grid_rows_q) < MIN_SIZE)
			live_h = ($clog2(MAX_ROWS+1))'(MIN_SIZE);
		else if (32'(grid_rows_q) > MAX_ROWS)
			live_h = ($clog2(MAX_ROWS+1))'(MAX_ROWS);
		else
			live_h = ($clog2(MAX_ROWS+1))'(grid_rows_q);
	end

	assign last_col = CIW'(live_w - WW'(1));
	assign col_idx  = CIW'(col_q);
	assign in_area  = (32'(col_q) < 32'(live_w)) && (32'(row_q) < 32'(live_h));
	assign status.action = action_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= COLS_RESET;
			grid_rows_q    <= ROWS_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_GRID_COLUMNS: grid_columns_q <= cfg_wdata[COLS_CFG_W-1:0];
				CFG_GRID_ROWS:    grid_rows_q    <= cfg_wdata[ROWS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// neighbors of every column, wrapped at the live width
	assign ul = wrap_left(up_q, last_col);
	assign ur = wrap_right(up_q, last_col);
	assign ml = wrap_left(mid_q, last_col);
	assign mr = wrap_right(mid_q, last_col);
	assign dl = wrap_left(rd_data_q, last_col);
	assign dr = wrap_right(rd_data_q, last_col);

	always_comb begin
		nbr_cnt = '0;
		for (int c = 0; c < MAX_COLUMNS; c++) begin
			nbr_cnt = 4'(ul[c]) + 4'(up_q[c]) + 4'(ur[c]) + 4'(ml[c]) + 4'(mr[c])
				+ 4'(dl[c]) + 4'(rd_data_q[c]) + 4'(dr[c]);
			gen_row[c]  = (nbr_cnt == BIRTH_COUNT) || ((nbr_cnt == KEEP_COUNT) && mid_q[c]);
			gen_mask[c] = (32'(c) < 32'(live_w));
		end
	end

	always_comb begin
		rd_addr = {cmd.rd_plane, cmd.rd_item ? RW'(row_q) : rd_row};
		case (cmd.wr_kind)
			WR_CLEAR: begin
				wr_addr = {cmd.wr_plane, wr_row};
				wr_data = '0;
				wr_mask = '1;
			end
			WR_CELL: begin
				wr_addr = {cmd.wr_plane, RW'(row_q)};
				wr_data = {MAX_COLUMNS{cell_in_q}};
				wr_mask = {{(MAX_COLUMNS-1){1'b0}}, in_area} << col_idx;
			end
			WR_GEN: begin
				wr_addr = {cmd.wr_plane, wr_row};
				wr_data = gen_row;
				wr_mask = gen_mask;
			end
			default: begin
				wr_addr = {cmd.wr_plane, wr_row};
				wr_data = '0;
				wr_mask = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			for (int i = 0; i < MAX_COLUMNS; i++) begin
				if (wr_mask[i])
					grid_mem[wr_addr][i] <= wr_data[i];
			end
		end
		if (cmd.rd_en)
			rd_data_q <= grid_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			action_q  <= action_t'(s_tuser);
			col_q     <= s_tdata[COL_W-1:0];
			row_q     <= s_tdata[COL_W+ROW_W-1:COL_W];
			cell_in_q <= s_tdata[COL_W+ROW_W];
		end
		// slide the row window down by one
		if (cmd.win_shift) begin
			up_q  <= mid_q;
			mid_q <= rd_data_q;
		end
		if (cmd.cell_latch)
			cell_q <= in_area & rd_data_q[col_idx];
		if (cmd.out_load) begin
			done_action_q <= action_q;
			cell_out_q    <= (action_q == ACT_READ) ? cell_q : 1'b0;
		end
	end

	assign m_tdata = M_DATA_W'(cell_out_q);
	assign m_tuser = done_action_q;

endmodule

/* design/lat_ctrl.sv */
// ----------------------------------------------------------------------------
// lat_ctrl
// Sequencer of the life automaton: clearing pass, item dispatch, row sweep of
// an advance, plane select and the result handshake.
// ----------------------------------------------------------------------------
module lat_ctrl #(
	parameter int MAX_ROWS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	input  lat_pkg::status_t              status,
	input  logic [$clog2(MAX_ROWS+1)-1:0] live_h,
	output lat_pkg::cmd_t                 cmd,
	output logic [$clog2(MAX_ROWS)-1:0]   rd_row,
	output logic [$clog2(MAX_ROWS)-1:0]   wr_row
);
	import lat_pkg::*;

	localparam int RW = $clog2(MAX_ROWS);
	localparam int AW = RW + 1;
	localparam int JW = $clog2(MAX_ROWS + 3);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_RWAIT,
		ST_ADV,
		ST_FINISH
	} state_t;

	state_t        state_q;
	logic [AW-1:0] clr_q;
	logic [JW-1:0] j_q;
	logic [JW-1:0] j_s1;
	logic          adv_v_s1;
	logic          plane_q;
	logic          out_valid_q;
	logic          issue;
	logic          adv_end;
	logic          out_free;

	// sweep reads rows h-1, 0, 1 .. h-1, 0 so each row sees both wrap neighbours
	assign issue    = (32'(j_q) <= 32'(live_h) + 32'd1);
	assign adv_end  = !issue && !adv_v_s1;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		if (j_q == '0)
			rd_row = RW'(32'(live_h) - 32'd1);
		else if (32'(j_q) == 32'(live_h) + 32'd1)
			rd_row = '0;
		else
			rd_row = RW'(32'(j_q) - 32'd1);
	end

	always_comb begin
		cmd    = '0;
		wr_row = RW'(32'(j_s1) - 32'd2);
		case (state_q)
			ST_CLEAR: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_kind  = WR_CLEAR;
				cmd.wr_plane = clr_q[AW-1];
				wr_row       = clr_q[RW-1:0];
			end
			ST_IDLE: begin
				cmd.item_load = s_tvalid;
			end
			ST_DISPATCH: begin
				case (status.action)
					ACT_WRITE: begin
						cmd.wr_en    = 1'b1;
						cmd.wr_kind  = WR_CELL;
						cmd.wr_plane = plane_q;
					end
					ACT_READ: begin
						cmd.rd_en    = 1'b1;
						cmd.rd_item  = 1'b1;
						cmd.rd_plane = plane_q;
					end
					default: ;
				endcase
			end
			ST_RWAIT: begin
				cmd.cell_latch = 1'b1;
			end
			ST_ADV: begin
				cmd.rd_en     = issue;
				cmd.rd_plane  = plane_q;
				cmd.win_shift = adv_v_s1;
				cmd.wr_en     = adv_v_s1 && (32'(j_s1) >= 32'd2);
				cmd.wr_kind   = WR_GEN;
				cmd.wr_plane  = !plane_q;
			end
			ST_FINISH: begin
				cmd.out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			j_q         <= '0;
			j_s1        <= '0;
			adv_v_s1    <= 1'b0;
			plane_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			adv_v_s1 <= (state_q == ST_ADV) && issue;
			j_s1     <= j_q;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (&clr_q)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_DISPATCH;
				end
				ST_DISPATCH: begin
					j_q <= '0;
					case (status.action)
						ACT_READ:    state_q <= ST_RWAIT;
						ACT_ADVANCE: state_q <= ST_ADV;
						default:     state_q <= ST_FINISH;
					endcase
				end
				ST_RWAIT: begin
					state_q <= ST_FINISH;
				end
				ST_ADV: begin
					if (issue)
						j_q <= j_q + JW'(1);
					// swap planes once the last row is written
					if (adv_end) begin
						plane_q <= !plane_q;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_plane_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV && adv_end) |=> (plane_q != $past(plane_q)))
		else $error("plane select did not flip at the end of an advance");

	a_gen_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_en && cmd.wr_kind == WR_GEN) |-> (32'(wr_row) < 32'(live_h)))
		else $error("generation write outside the live rows");

	a_accept_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> (!adv_v_s1 && !cmd.wr_en))
		else $error("word accepted while the sweep or a write is in flight");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("loaded result not presented");

endmodule

/* design/life_automaton_torus.sv */
// ----------------------------------------------------------------------------
// life_automaton_torus
// Game of life on a wrap-around grid of configurable size, two cell planes.
// ----------------------------------------------------------------------------
// Each input word writes a cell, reads a cell or advances one generation (the
// unused action code does nothing), and gives exactly one result word. A write
// goes from the dispatch state to the finish state, which loads the result
// register; a read passes a wait state between them, set by the registered
// read of the row memory. In an advance the single read port of the row memory
// delivers one row per cycle, the sweep reads live_rows + 2 rows (the wrap
// rows twice) and writes each new row into the other plane. The next word can
// be taken in the cycle after the result is loaded, and not before. After
// reset a clearing pass zeroes all 2 * 2**clog2(MAX_ROWS) rows (512 by
// default), one row per cycle, before the first word is taken; size registers
// can be written during it. A word can be accepted while the previous result
// still waits on the output.
module life_automaton_torus #(
	parameter int MAX_COLUMNS = 512,
	parameter int MAX_ROWS    = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [lat_pkg::S_DATA_W-1:0]   s_tdata,   // column[8:0], row[16:9], cell_in[17], zero
	input  logic [lat_pkg::ACT_W-1:0]      s_tuser,   // action[1:0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lat_pkg::M_DATA_W-1:0]   m_tdata,   // cell_out[0], zero
	output logic [lat_pkg::ACT_W-1:0]      m_tuser,   // done_action[1:0]
	input  logic                           cfg_we,
	input  logic [lat_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lat_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import lat_pkg::*;

	cmd_t                          cmd;
	status_t                       status;
	logic [$clog2(MAX_ROWS+1)-1:0] live_h;
	logic [$clog2(MAX_ROWS)-1:0]   rd_row;
	logic [$clog2(MAX_ROWS)-1:0]   wr_row;

	lat_ctrl #(
		.MAX_ROWS (MAX_ROWS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.status   (status),
		.live_h   (live_h),
		.cmd      (cmd),
		.rd_row   (rd_row),
		.wr_row   (wr_row)
	);

	lat_datapath #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.rd_row    (rd_row),
		.wr_row    (wr_row),
		.status    (status),
		.live_h    (live_h),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
